// File: hdl/lossy_error_stats_accumulator_macros.svh
// Assertion macros shared by the checker of the error statistics block.
`ifndef LOSSY_ERROR_STATS_ACCUMULATOR_MACROS_SVH
`define LOSSY_ERROR_STATS_ACCUMULATOR_MACROS_SVH
// Same-cycle implication, sampled on the rising clock, idle in reset.
`define LES_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, sampled on the rising clock, idle in reset.
`define LES_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// File: hdl/les_pkg.sv
// Types, constants and register indexes of the error statistics block.
package les_pkg;
  localparam int unsigned IndexBitsDefault = 32;
  localparam logic [31:0] RelBoundReset = 32'd168;
  localparam logic [31:0] AbsBoundReset = 32'd3277;
  localparam int unsigned QueueDepth = 2;

  typedef enum logic {
    REG_REL_BOUND = 1'b0,
    REG_ABS_BOUND = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    FRONT_IDLE,
    FRONT_DIV,
    FRONT_PUSH
  } front_state_e;

  typedef struct packed {
    logic signed [31:0] original_value;
    logic signed [31:0] reconstructed_value;
    logic               last_item;
  } in_t;

  typedef struct packed {
    logic        [32:0] worst_abs_error;
    logic        [31:0] worst_rel_error;
    logic        [31:0] max_rel_index;
    logic signed [31:0] max_rel_original;
    logic signed [31:0] max_rel_reconstructed;
    logic        [31:0] rel_violations;
    logic        [31:0] abs_violations;
    logic        [31:0] peak_magnitude;
    logic signed [31:0] min_original;
    logic signed [31:0] max_original;
    logic        [63:0] sum_squared_error;
    logic        [31:0] item_total;
  } out_t;

  typedef struct packed {
    logic signed [31:0] orig;
    logic signed [31:0] recon;
    logic               last;
    logic        [32:0] abs_err;
    logic        [31:0] mag;
    logic        [31:0] rel;
    logic        [63:0] sq;
  } item_t;
endpackage

// File: hdl/les_front.sv
// Front end: takes a sample pair, forms its errors and divides out the relative error.
module les_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  input  les_pkg::in_t      data_i,
  output logic              full,
  output logic              item_valid_o,
  output les_pkg::item_t    item_o,
  input  logic              item_ready_i
);
  import les_pkg::*;

  front_state_e state_q, state_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [31:0] rem_q, rem_d;
  logic [31:0] quo_q, quo_d;
  logic signed [31:0] orig_q, recon_q;
  logic        last_q;
  logic [32:0] abs_q, abs_in;
  logic [31:0] mag_q, mag_in;
  logic [63:0] sq_q;
  logic signed [32:0] diff;
  logic [32:0] trial;
  logic        sat;
  logic        load;

  assign diff   = 33'(data_i.original_value) - 33'(data_i.reconstructed_value);
  assign abs_in = diff[32] ? 33'(-diff) : 33'(diff);
  assign mag_in = data_i.original_value[31] ? 32'(-33'(data_i.original_value))
                                            : 32'(data_i.original_value);
  assign trial  = {rem_q, quo_q[31]};
  assign sat    = {8'd0, abs_q} >= {1'b0, mag_q, 8'd0};
  assign load   = push && !full;

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    rem_d        = rem_q;
    quo_d        = quo_q;
    full         = 1'b1;
    item_valid_o = 1'b0;
    unique case (state_q)
      FRONT_IDLE: begin
        full = 1'b0;
        if (load) begin
          state_d = FRONT_DIV;
          cnt_d   = '0;
          rem_d   = 32'(abs_in >> 8);
          quo_d   = {abs_in[7:0], 24'd0};
        end
      end
      FRONT_DIV: begin
        if (trial >= {1'b0, mag_q}) begin
          rem_d = 32'(trial - {1'b0, mag_q});
          quo_d = {quo_q[30:0], 1'b1};
        end else begin
          rem_d = trial[31:0];
          quo_d = {quo_q[30:0], 1'b0};
        end
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          state_d = FRONT_PUSH;
        end
      end
      FRONT_PUSH: begin
        item_valid_o = 1'b1;
        if (item_ready_i) begin
          state_d = FRONT_IDLE;
        end
      end
      default: state_d = FRONT_IDLE;
    endcase
  end

  always_comb begin
    item_o.orig    = orig_q;
    item_o.recon   = recon_q;
    item_o.last    = last_q;
    item_o.abs_err = abs_q;
    item_o.mag     = mag_q;
    item_o.sq      = sq_q;
    if (mag_q == '0) begin
      item_o.rel = '0;
    end else if (sat) begin
      item_o.rel = '1;
    end else begin
      item_o.rel = quo_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FRONT_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    sq_q  <= abs_q[32] ? '1 : 64'(abs_q[31:0] * abs_q[31:0]);
    if (load) begin
      orig_q  <= data_i.original_value;
      recon_q <= data_i.reconstructed_value;
      last_q  <= data_i.last_item;
      abs_q   <= abs_in;
      mag_q   <= mag_in;
    end
  end
endmodule

// File: hdl/les_queue.sv
// Short queue that decouples the front end from the accumulating back end.
module les_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_valid_i,
  output logic           wr_ready_o,
  input  les_pkg::item_t wr_item_i,
  output logic           rd_valid_o,
  input  logic           rd_ready_i,
  output les_pkg::item_t rd_item_o
);
  import les_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);

  item_t          mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]   fill_q;
  logic            wr_en, rd_en;

  assign wr_ready_o = fill_q != (PtrW+1)'(QueueDepth);
  assign rd_valid_o = fill_q != '0;
  assign wr_en      = wr_valid_i && wr_ready_o;
  assign rd_en      = rd_valid_o && rd_ready_i;
  assign rd_item_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (rd_en) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (wr_en && !rd_en) begin
        fill_q <= fill_q + (PtrW+1)'(1);
      end else if (rd_en && !wr_en) begin
        fill_q <= fill_q - (PtrW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= wr_item_i;
    end
  end
endmodule

// File: hdl/les_back.sv
// Back end: folds each classified pair into the statistics and emits the totals.
module les_back #(
  parameter int unsigned INDEX_BITS = les_pkg::IndexBitsDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic           cfg_index_i,
  input  logic [31:0]    cfg_data_i,
  input  logic           item_valid_i,
  output logic           item_ready_o,
  input  les_pkg::item_t item_i,
  output logic           empty,
  input  logic           pop,
  output les_pkg::out_t  data_o
);
  import les_pkg::*;

  logic [31:0]          rel_bound_q, abs_bound_q;
  logic [32:0]          best_abs_q, best_abs_d;
  logic [31:0]          best_rel_q, best_rel_d;
  logic [INDEX_BITS-1:0] best_idx_q, best_idx_d;
  logic signed [31:0]   best_orig_q, best_orig_d, best_recon_q, best_recon_d;
  logic [31:0]          rel_cnt_q, rel_cnt_d, abs_cnt_q, abs_cnt_d;
  logic [31:0]          peak_q, peak_d;
  logic signed [31:0]   low_q, low_d, high_q, high_d;
  logic [63:0]          ssum_q, ssum_d;
  logic [64:0]          ssum_ext;
  logic [31:0]          pairs_q, pairs_d;
  logic                 seen_q;
  logic [INDEX_BITS+31:0] idx_ext, idx_out;
  logic                 take;
  logic                 out_valid_q;
  out_t                 out_q;

  assign item_ready_o = !item_i.last || !out_valid_q;
  assign take         = item_valid_i && item_ready_o;
  assign empty        = !out_valid_q;
  assign data_o       = out_q;
  assign idx_ext      = (INDEX_BITS+32)'(pairs_q);
  assign idx_out      = (INDEX_BITS+32)'(best_idx_d);
  assign ssum_ext     = {1'b0, ssum_q} + {1'b0, item_i.sq};

  always_comb begin
    best_rel_d   = best_rel_q;
    best_idx_d   = best_idx_q;
    best_orig_d  = best_orig_q;
    best_recon_d = best_recon_q;
    if (!seen_q || item_i.rel > best_rel_q) begin
      best_rel_d   = item_i.rel;
      best_idx_d   = idx_ext[INDEX_BITS-1:0];
      best_orig_d  = item_i.orig;
      best_recon_d = item_i.recon;
    end
    rel_cnt_d  = (item_i.rel > rel_bound_q && rel_cnt_q != '1) ? rel_cnt_q + 32'd1 : rel_cnt_q;
    abs_cnt_d  = (item_i.abs_err > {1'b0, abs_bound_q} && abs_cnt_q != '1)
               ? abs_cnt_q + 32'd1 : abs_cnt_q;
    best_abs_d = (item_i.abs_err > best_abs_q) ? item_i.abs_err : best_abs_q;
    peak_d     = (item_i.mag > peak_q) ? item_i.mag : peak_q;
    low_d      = (item_i.orig < low_q) ? item_i.orig : low_q;
    high_d     = (item_i.orig > high_q) ? item_i.orig : high_q;
    ssum_d     = ssum_ext[64] ? '1 : ssum_ext[63:0];
    pairs_d    = (pairs_q != '1) ? pairs_q + 32'd1 : pairs_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rel_bound_q  <= RelBoundReset;
      abs_bound_q  <= AbsBoundReset;
      out_valid_q  <= 1'b0;
      seen_q       <= 1'b0;
      best_abs_q   <= '0;
      best_rel_q   <= '0;
      best_idx_q   <= '0;
      best_orig_q  <= '0;
      best_recon_q <= '0;
      rel_cnt_q    <= '0;
      abs_cnt_q    <= '0;
      peak_q       <= '0;
      low_q        <= 32'sh7FFF_FFFF;
      high_q       <= 32'sh8000_0000;
      ssum_q       <= '0;
      pairs_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          REG_REL_BOUND: rel_bound_q <= cfg_data_i;
          REG_ABS_BOUND: abs_bound_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (pop && out_valid_q) begin
        out_valid_q <= 1'b0;
      end
      if (take) begin
        if (item_i.last) begin
          out_valid_q  <= 1'b1;
          seen_q       <= 1'b0;
          best_abs_q   <= '0;
          best_rel_q   <= '0;
          best_idx_q   <= '0;
          best_orig_q  <= '0;
          best_recon_q <= '0;
          rel_cnt_q    <= '0;
          abs_cnt_q    <= '0;
          peak_q       <= '0;
          low_q        <= 32'sh7FFF_FFFF;
          high_q       <= 32'sh8000_0000;
          ssum_q       <= '0;
          pairs_q      <= '0;
        end else begin
          seen_q       <= 1'b1;
          best_abs_q   <= best_abs_d;
          best_rel_q   <= best_rel_d;
          best_idx_q   <= best_idx_d;
          best_orig_q  <= best_orig_d;
          best_recon_q <= best_recon_d;
          rel_cnt_q    <= rel_cnt_d;
          abs_cnt_q    <= abs_cnt_d;
          peak_q       <= peak_d;
          low_q        <= low_d;
          high_q       <= high_d;
          ssum_q       <= ssum_d;
          pairs_q      <= pairs_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && item_i.last) begin
      out_q.worst_abs_error       <= best_abs_d;
      out_q.worst_rel_error       <= best_rel_d;
      out_q.max_rel_index         <= idx_out[31:0];
      out_q.max_rel_original      <= best_orig_d;
      out_q.max_rel_reconstructed <= best_recon_d;
      out_q.rel_violations        <= rel_cnt_d;
      out_q.abs_violations        <= abs_cnt_d;
      out_q.peak_magnitude        <= peak_d;
      out_q.min_original          <= low_d;
      out_q.max_original          <= high_d;
      out_q.sum_squared_error     <= ssum_d;
      out_q.item_total            <= pairs_d;
    end
  end
endmodule

// File: hdl/lossy_error_stats_accumulator.sv
// Top level of the error statistics block for original and reconstructed samples.
// Input channel: data_i carries one pair of signed Q16.16 samples per beat, taken
// when push is high and full is low. A beat with last_item set closes the run.
// Result channel: one beat of totals per run, shown on data_o while empty is low
// and taken when pop is high. Runs without last_item produce no beat.
// Configuration: cfg_we_i writes cfg_data_i to register cfg_index_i
// (0 relative bound, 1 absolute bound); write only while the block is idle.
// The bit-serial divider of the front end takes a new pair only once the last is
// handed on: a load step, 32 quotient steps and a hand-over step that may stall.
// The totals appear once the closing pair has passed divider, queue and back end.
// A two-entry queue separates the divider from the accumulators, so a stalled
// result only holds back the back end once a second closing pair arrives.
// Reset clears the statistics, empties the queue and restores the bounds.
module lossy_error_stats_accumulator #(
  parameter int unsigned INDEX_BITS = les_pkg::IndexBitsDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push,
  output logic          full,
  input  les_pkg::in_t  data_i,
  output logic          empty,
  input  logic          pop,
  output les_pkg::out_t data_o,
  input  logic          cfg_we_i,
  input  logic          cfg_index_i,
  input  logic [31:0]   cfg_data_i
);
  import les_pkg::*;

  logic  f_valid, f_ready, b_valid, b_ready;
  item_t f_item, b_item;

  les_front u_front (
    .clk_i, .rst_ni, .push, .data_i, .full,
    .item_valid_o(f_valid), .item_o(f_item), .item_ready_i(f_ready)
  );

  les_queue u_queue (
    .clk_i, .rst_ni,
    .wr_valid_i(f_valid), .wr_ready_o(f_ready), .wr_item_i(f_item),
    .rd_valid_o(b_valid), .rd_ready_i(b_ready), .rd_item_o(b_item)
  );

  les_back #(.INDEX_BITS(INDEX_BITS)) u_back (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .item_valid_i(b_valid), .item_ready_o(b_ready), .item_i(b_item),
    .empty, .pop, .data_o
  );
endmodule

// File: hdl/les_checker.sv
// Port checker for the error statistics block and its bind statement.
`include "lossy_error_stats_accumulator_macros.svh"
module les_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          push,
  input logic          full,
  input logic          empty,
  input logic          pop,
  input les_pkg::out_t data_o
);
  `LES_ASSERT_NXT(busy_after_take, push && !full, full)
  `LES_ASSERT_NXT(result_held, !empty && !pop, !empty)
  `LES_ASSERT_IMP(total_nonzero, !empty, data_o.item_total != 32'd0)
  `LES_ASSERT_IMP(range_ordered, !empty, $signed(data_o.min_original) <= $signed(data_o.max_original))
endmodule

bind lossy_error_stats_accumulator les_checker u_les_checker (.*);
